/* rtl/core/gsp_pkg.sv */
// ----------------------------------------------------------------------------
// gsp_pkg: shared types and codes for the generational slot pool
// Word layouts of the three channels, operation and status codes, slot states
// and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package gsp_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 40;
  localparam int unsigned TOTAL_W    = 40;

  typedef enum logic [2:0] {
    MODE_RESERVE  = 3'd0,
    MODE_PUBLISH  = 3'd1,
    MODE_ROLLBACK = 3'd2,
    MODE_GET      = 3'd3,
    MODE_RELEASE  = 3'd4
  } mode_t;

  typedef enum logic [3:0] {
    STS_OK         = 4'd0,
    STS_BAD_MESH   = 4'd1,
    STS_BAD_CONFIG = 4'd2,
    STS_NO_SLOT    = 4'd3,
    STS_POS_BUDGET = 4'd4,
    STS_IDX_BUDGET = 4'd5,
    STS_BYTE_BUDGET = 4'd6,
    STS_BAD_RESV   = 4'd7,
    STS_BAD_HANDLE = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    SLOT_FREE     = 2'd0,
    SLOT_RESERVED = 2'd1,
    SLOT_RESIDENT = 2'd2,
    SLOT_RETIRED  = 2'd3
  } slot_state_t;

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'd0,
    SEQ_PREP = 2'd1,
    SEQ_EXEC = 2'd2
  } seq_state_t;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_ID   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_BUDG  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BUDG  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_BUDG = 2'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [32:0] pos_count;
    logic [31:0] index_count;
    logic [35:0] claimed_bytes;
    logic        mesh_content_ok;
    logic [15:0] handle_pool;
    logic [15:0] handle_generation;
    logic [5:0]  handle_slot;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [5:0]  out_slot;
    logic [15:0] out_generation;
    logic [32:0] out_positions;
    logic [31:0] out_indices;
    logic [35:0] out_bytes;
  } out_word_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_word_t;

  // 4 = 1 mod 3, so base-4 digit sums keep the residue
  function automatic logic mod3_zero(input logic [31:0] x);
    logic [5:0] s;
    logic [3:0] t;
    s = '0;
    for (int i = 0; i < 16; i++) begin
      s = s + 6'(x[2*i +: 2]);
    end
    t = 4'(s[1:0]) + 4'(s[3:2]) + 4'(s[5:4]);
    return (t == 4'd0) || (t == 4'd3) || (t == 4'd6) || (t == 4'd9);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/gsp_if.sv */
// ----------------------------------------------------------------------------
// gsp channel interfaces
// Valid/ready channels for operation words, result words and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface gsp_in_if import gsp_pkg::*; ;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gsp_out_if import gsp_pkg::*; ;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gsp_cfg_if import gsp_pkg::*; ;
  logic      valid;
  logic      ready;
  cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/generational_slot_pool_with_budgets_top.sv */
// ----------------------------------------------------------------------------
// generational_slot_pool_with_budgets_top: slot allocator with budgets
// LIFO free list, per-slot generation and three running budgets, all slot
// state held in one single-port-read synchronous memory.
// ----------------------------------------------------------------------------
// Order: the slot entry is read at the accepting edge; the word then passes
//   the prepare and execute states, and the result word is registered there.
// Flow: a new word is accepted only back in idle; a stalled result word holds
//   the execute stage and with it the input.
// Reset: synchronous, active low. A clearing pass then initializes the slot
//   memory; no word is accepted until it ends.
//   Register writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module generational_slot_pool_with_budgets_top
  import gsp_pkg::*;
#(
  parameter int unsigned SLOTS          = 64,
  parameter int unsigned GEN_BITS       = 16,
  parameter int unsigned BYTES_PER_POS  = 12
) (
  input  wire logic clk,
  input  wire logic rst_n,
  gsp_in_if.sink    in_bus,
  gsp_out_if.source out_bus,
  gsp_cfg_if.sink   cfg_bus
);

  localparam int unsigned SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned LINK_W  = $clog2(SLOTS + 1);
  localparam int unsigned HS_W    = (SLOT_W > 6) ? SLOT_W : 6;
  localparam int unsigned GCMP_W  = (GEN_BITS > 16) ? GEN_BITS : 16;
  localparam int unsigned BYTES_W = 33 + $clog2(BYTES_PER_POS + 1) + 1;
  localparam int unsigned ROOM_W  = TOTAL_W + 1;
  localparam logic [LINK_W-1:0]   NO_LINK = LINK_W'(SLOTS);
  localparam logic [GEN_BITS-1:0] GEN_MAX = '1;

  typedef struct packed {
    logic [1:0]          state;
    logic [GEN_BITS-1:0] gen;
    logic [LINK_W-1:0]   link;
    logic [32:0]         positions;
    logic [31:0]         indices;
    logic [35:0]         bytes;
  } entry_t;

  // registers
  logic [15:0]        pool_id_r;
  logic [TOTAL_W-1:0] pos_budget_r, idx_budget_r, byte_budget_r;
  logic [TOTAL_W-1:0] rsv_pos_r, rsv_idx_r, rsv_byte_r;
  logic [TOTAL_W-1:0] res_pos_r, res_idx_r, res_byte_r;
  logic [TOTAL_W-1:0] rsv_pos_nxt, rsv_idx_nxt, rsv_byte_nxt;
  logic [TOTAL_W-1:0] res_pos_nxt, res_idx_nxt, res_byte_nxt;
  logic [LINK_W-1:0]  free_head_r, free_head_nxt;
  logic [LINK_W-1:0]  free_count_r, free_count_nxt;
  logic               clearing_r;
  logic [SLOT_W-1:0]  clr_cnt_r;
  seq_state_t         state_r, state_nxt;
  in_word_t           op_r;
  entry_t             rdata_r;
  logic [BYTES_W-1:0] bytes_r;
  logic               mesh_bad_r;
  logic [TOTAL_W-1:0] room_pos_r, room_idx_r, room_byte_r;
  logic               out_valid_r;
  out_word_t          out_data_r;

  entry_t mem [SLOTS];

  logic              in_fire, exec_fire, out_free;
  logic              we;
  logic [SLOT_W-1:0] wa;
  entry_t            wd;
  logic [SLOT_W-1:0] rd_addr;
  logic [HS_W-1:0]   hs_ext;
  logic [HS_W-1:0]   hs_op;
  logic [SLOT_W-1:0] op_slot;
  out_word_t         res;

  assign hs_ext   = HS_W'(in_bus.data.handle_slot);
  assign hs_op    = HS_W'(op_r.handle_slot);
  assign op_slot  = hs_op[SLOT_W-1:0];
  assign in_fire  = in_bus.valid && in_bus.ready;
  assign out_free = !out_valid_r || out_bus.ready;
  assign rd_addr  = (in_bus.data.mode == MODE_RESERVE) ? free_head_r[SLOT_W-1:0]
                                                       : hs_ext[SLOT_W-1:0];

  // configuration
  assign cfg_bus.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_id_r     <= '0;
      pos_budget_r  <= '1;
      idx_budget_r  <= '1;
      byte_budget_r <= '1;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.data.index)
        CFG_POOL_ID:   pool_id_r     <= cfg_bus.data.data[15:0];
        CFG_POS_BUDG:  pos_budget_r  <= cfg_bus.data.data;
        CFG_IDX_BUDG:  idx_budget_r  <= cfg_bus.data.data;
        CFG_BYTE_BUDG: byte_budget_r <= cfg_bus.data.data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SEQ_IDLE: if (in_fire) state_nxt = SEQ_PREP;
      SEQ_PREP: state_nxt = SEQ_EXEC;
      SEQ_EXEC: if (out_free) state_nxt = SEQ_IDLE;
      default:  state_nxt = SEQ_IDLE;
    endcase
  end

  always_comb begin
    in_bus.ready = (state_r == SEQ_IDLE) && !clearing_r;
    exec_fire    = (state_r == SEQ_EXEC) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= SEQ_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (32'(clr_cnt_r) == SLOTS - 1) clearing_r <= 1'b0;
    end
  end

  // capture and prepare stage: shape checks, byte cost and budget room
  function automatic logic [TOTAL_W-1:0] room_of(input logic [TOTAL_W-1:0] budget,
                                                 input logic [TOTAL_W-1:0] a,
                                                 input logic [TOTAL_W-1:0] b);
    logic [ROOM_W-1:0] charged;
    charged = ROOM_W'(a) + ROOM_W'(b);
    return (charged > ROOM_W'(budget)) ? '0 : TOTAL_W'(ROOM_W'(budget) - charged);
  endfunction

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r    <= in_bus.data;
      rdata_r <= mem[rd_addr];
    end
    if (state_r == SEQ_PREP) begin
      bytes_r <= BYTES_W'(op_r.pos_count) * BYTES_W'(BYTES_PER_POS)
               + (BYTES_W'(op_r.index_count) << 2);
      mesh_bad_r <= (op_r.pos_count == '0) || (op_r.index_count == '0) ||
                    !mod3_zero(op_r.index_count) ||
                    (op_r.pos_count[32] && (op_r.pos_count[31:0] != '0)) ||
                    !op_r.mesh_content_ok;
      room_pos_r  <= room_of(pos_budget_r, rsv_pos_r, res_pos_r);
      room_idx_r  <= room_of(idx_budget_r, rsv_idx_r, res_idx_r);
      room_byte_r <= room_of(byte_budget_r, rsv_byte_r, res_byte_r);
    end
  end

  // execute stage
  logic   bad_cost, pool_on, slot_ok, gen_ok, amounts_ok, retire;
  entry_t freed;

  always_comb begin
    bad_cost   = bytes_r > BYTES_W'(36'hF_FFFF_FFFF);
    pool_on    = pool_id_r != '0;
    slot_ok    = pool_on && (op_r.handle_pool == pool_id_r) &&
                 (32'(op_r.handle_slot) < SLOTS);
    gen_ok     = GCMP_W'(rdata_r.gen) == GCMP_W'(op_r.handle_generation);
    amounts_ok = (rdata_r.positions == op_r.pos_count) &&
                 (rdata_r.indices == op_r.index_count) &&
                 (rdata_r.bytes == op_r.claimed_bytes);
    retire     = rdata_r.gen == GEN_MAX;

    freed           = rdata_r;
    freed.positions = '0;
    freed.indices   = '0;
    freed.bytes     = '0;
    if (retire) begin
      freed.state = SLOT_RETIRED;
      freed.link  = NO_LINK;
    end else begin
      freed.state = SLOT_FREE;
      freed.gen   = rdata_r.gen + 1'b1;
      freed.link  = free_head_r;
    end
  end

  always_comb begin
    res            = '0;
    res.status     = STS_OK;
    we             = 1'b0;
    wa             = clr_cnt_r;
    wd             = rdata_r;
    free_head_nxt  = free_head_r;
    free_count_nxt = free_count_r;
    rsv_pos_nxt    = rsv_pos_r;
    rsv_idx_nxt    = rsv_idx_r;
    rsv_byte_nxt   = rsv_byte_r;
    res_pos_nxt    = res_pos_r;
    res_idx_nxt    = res_idx_r;
    res_byte_nxt   = res_byte_r;

    if (clearing_r) begin
      we    = 1'b1;
      wd    = '0;
      wd.state = SLOT_FREE;
      wd.link  = LINK_W'(clr_cnt_r) + 1'b1;
    end else if (exec_fire) begin
      unique case (op_r.mode)
        MODE_RESERVE: begin
          priority if (mesh_bad_r || bad_cost) res.status = STS_BAD_MESH;
          else if (!pool_on) res.status = STS_BAD_CONFIG;
          else if ((free_count_r == '0) || (free_head_r >= NO_LINK))
            res.status = STS_NO_SLOT;
          else if (TOTAL_W'(op_r.pos_count) > room_pos_r) res.status = STS_POS_BUDGET;
          else if (TOTAL_W'(op_r.index_count) > room_idx_r) res.status = STS_IDX_BUDGET;
          else if (TOTAL_W'(bytes_r[35:0]) > room_byte_r) res.status = STS_BYTE_BUDGET;
          else begin
            we             = 1'b1;
            wa             = free_head_r[SLOT_W-1:0];
            wd.state       = SLOT_RESERVED;
            wd.link        = NO_LINK;
            wd.positions   = op_r.pos_count;
            wd.indices     = op_r.index_count;
            wd.bytes       = bytes_r[35:0];
            free_head_nxt  = rdata_r.link;
            free_count_nxt = free_count_r - 1'b1;
            rsv_pos_nxt    = rsv_pos_r + TOTAL_W'(op_r.pos_count);
            rsv_idx_nxt    = rsv_idx_r + TOTAL_W'(op_r.index_count);
            rsv_byte_nxt   = rsv_byte_r + TOTAL_W'(bytes_r[35:0]);
            res.out_slot       = 6'(free_head_r);
            res.out_generation = 16'(rdata_r.gen);
            res.out_positions  = op_r.pos_count;
            res.out_indices    = op_r.index_count;
            res.out_bytes      = bytes_r[35:0];
          end
        end
        MODE_PUBLISH, MODE_ROLLBACK: begin
          if (!(slot_ok && gen_ok && rdata_r.state == SLOT_RESERVED && amounts_ok)) begin
            res.status = STS_BAD_RESV;
          end else begin
            we           = 1'b1;
            wa           = op_slot;
            rsv_pos_nxt  = rsv_pos_r - TOTAL_W'(op_r.pos_count);
            rsv_idx_nxt  = rsv_idx_r - TOTAL_W'(op_r.index_count);
            rsv_byte_nxt = rsv_byte_r - TOTAL_W'(op_r.claimed_bytes);
            res.out_slot       = op_r.handle_slot;
            res.out_generation = op_r.handle_generation;
            res.out_positions  = op_r.pos_count;
            res.out_indices    = op_r.index_count;
            res.out_bytes      = op_r.claimed_bytes;
            if (op_r.mode == MODE_PUBLISH) begin
              wd.state     = SLOT_RESIDENT;
              res_pos_nxt  = res_pos_r + TOTAL_W'(op_r.pos_count);
              res_idx_nxt  = res_idx_r + TOTAL_W'(op_r.index_count);
              res_byte_nxt = res_byte_r + TOTAL_W'(op_r.claimed_bytes);
            end else begin
              wd = freed;
              if (!retire) begin
                free_head_nxt  = LINK_W'(op_slot);
                free_count_nxt = free_count_r + 1'b1;
              end
            end
          end
        end
        MODE_GET, MODE_RELEASE: begin
          if (!(slot_ok && gen_ok && rdata_r.state == SLOT_RESIDENT)) begin
            res.status = STS_BAD_HANDLE;
          end else begin
            res.out_slot       = op_r.handle_slot;
            res.out_generation = op_r.handle_generation;
            res.out_positions  = rdata_r.positions;
            res.out_indices    = rdata_r.indices;
            res.out_bytes      = rdata_r.bytes;
            if (op_r.mode == MODE_RELEASE) begin
              we           = 1'b1;
              wa           = op_slot;
              wd           = freed;
              res_pos_nxt  = res_pos_r - TOTAL_W'(rdata_r.positions);
              res_idx_nxt  = res_idx_r - TOTAL_W'(rdata_r.indices);
              res_byte_nxt = res_byte_r - TOTAL_W'(rdata_r.bytes);
              if (!retire) begin
                free_head_nxt  = LINK_W'(op_slot);
                free_count_nxt = free_count_r + 1'b1;
              end
            end
          end
        end
        default: res.status = STS_BAD_HANDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r  <= '0;
      free_count_r <= LINK_W'(SLOTS);
      rsv_pos_r    <= '0;
      rsv_idx_r    <= '0;
      rsv_byte_r   <= '0;
      res_pos_r    <= '0;
      res_idx_r    <= '0;
      res_byte_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      free_head_r  <= free_head_nxt;
      free_count_r <= free_count_nxt;
      rsv_pos_r    <= rsv_pos_nxt;
      rsv_idx_r    <= rsv_idx_nxt;
      rsv_byte_r   <= rsv_byte_nxt;
      res_pos_r    <= res_pos_nxt;
      res_idx_r    <= res_idx_nxt;
      res_byte_r   <= res_byte_nxt;
      if (exec_fire)          out_valid_r <= 1'b1;
      else if (out_bus.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) out_data_r <= res;
  end

  assign out_bus.valid = out_valid_r;
  assign out_bus.data  = out_data_r;

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(free_count_r) <= SLOTS) else $error("free count above slot count");

  a_list_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (free_count_r == '0) == (free_head_r == NO_LINK))
    else $error("free list head and count disagree");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == SEQ_EXEC))
    else $error("result word without execute stage");

  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == SEQ_PREP) else $error("accepted word not prepared");

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for the generational slot pool with budgets
// Drives operation words and register writes, keeps its own model of the pool
// (free list, generations, budgets) and checks every result word in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import gsp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 64;
  localparam logic [63:0] M36 = 64'hF_FFFF_FFFF;
  localparam logic [63:0] M40 = 64'hFF_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 2_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  gsp_in_if  in_bus ();
  gsp_out_if out_bus ();
  gsp_cfg_if cfg_bus ();

  generational_slot_pool_with_budgets_top i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus.sink),
    .out_bus (out_bus.source),
    .cfg_bus (cfg_bus.sink)
  );

  always #4 clk = ~clk;

  // ---------------- pool model ----------------
  logic [15:0]  pool_ident;
  logic [63:0]  pos_limit, idx_limit, byte_limit;
  slot_state_t  slot_st [NSLOT];
  logic [15:0]  slot_gen_m [NSLOT];
  logic [6:0]   slot_nxt [NSLOT];
  logic [63:0]  slot_pos [NSLOT];
  logic [63:0]  slot_idx [NSLOT];
  logic [63:0]  slot_byt [NSLOT];
  logic [6:0]   free_top;
  int           free_cnt;
  logic [63:0]  rsv_pos, res_pos, rsv_idx, res_idx, rsv_byt, res_byt;

  out_word_t pending_results[$];
  int  fails = 0;
  int  burst_left = 0;
  longint cycles = 0;

  function automatic logic [63:0] headroom(input logic [63:0] lim, a, b);
    return (a + b > lim) ? 64'd0 : lim - (a + b);
  endfunction

  function automatic bit handle_ok(input in_word_t w, input slot_state_t need);
    return pool_ident != 0 && w.handle_pool == pool_ident &&
           slot_gen_m[w.handle_slot] == w.handle_generation &&
           slot_st[w.handle_slot] == need;
  endfunction

  task automatic free_slot(input int s);
    slot_pos[s] = 0;
    slot_idx[s] = 0;
    slot_byt[s] = 0;
    if (slot_gen_m[s] == 16'hFFFF) begin
      slot_st[s] = SLOT_RETIRED;
      slot_nxt[s] = 7'(NSLOT);
    end else begin
      slot_gen_m[s] = slot_gen_m[s] + 16'd1;
      slot_st[s] = SLOT_FREE;
      slot_nxt[s] = free_top;
      free_top = 7'(s);
      free_cnt++;
    end
  endtask

  task automatic pool_reset();
    pool_ident = 0;
    pos_limit = M40;
    idx_limit = M40;
    byte_limit = M40;
    for (int i = 0; i < NSLOT; i++) begin
      slot_st[i] = SLOT_FREE;
      slot_gen_m[i] = 0;
      slot_nxt[i] = 7'(i + 1);
      slot_pos[i] = 0;
      slot_idx[i] = 0;
      slot_byt[i] = 0;
    end
    free_top = 0;
    free_cnt = NSLOT;
    {rsv_pos, res_pos, rsv_idx, res_idx, rsv_byt, res_byt} = '0;
  endtask

  task automatic pool_apply(input in_word_t w, output out_word_t r);
    logic [63:0] pc, ic, cb, byt;
    int s;
    status_t st;
    r = '0;
    st = STS_OK;
    pc = 64'(w.pos_count);
    ic = 64'(w.index_count);
    cb = 64'(w.claimed_bytes);
    s = int'(w.handle_slot);
    case (w.mode)
      MODE_RESERVE: begin
        byt = pc * 12 + ic * 4;
        if (pc == 0 || ic == 0 || ic % 3 != 0 || pc > 64'h1_0000_0000 ||
            !w.mesh_content_ok || byt > M36) st = STS_BAD_MESH;
        else if (pool_ident == 0) st = STS_BAD_CONFIG;
        else if (free_cnt == 0 || free_top >= NSLOT) st = STS_NO_SLOT;
        else if (pc > headroom(pos_limit, rsv_pos, res_pos)) st = STS_POS_BUDGET;
        else if (ic > headroom(idx_limit, rsv_idx, res_idx)) st = STS_IDX_BUDGET;
        else if (byt > headroom(byte_limit, rsv_byt, res_byt)) st = STS_BYTE_BUDGET;
        else begin
          s = int'(free_top);
          free_top = slot_nxt[s];
          free_cnt--;
          slot_st[s] = SLOT_RESERVED;
          slot_nxt[s] = 7'(NSLOT);
          slot_pos[s] = pc;
          slot_idx[s] = ic;
          slot_byt[s] = byt;
          rsv_pos += pc;
          rsv_idx += ic;
          rsv_byt += byt;
          r.out_slot = 6'(s);
          r.out_generation = slot_gen_m[s];
          r.out_positions = 33'(pc);
          r.out_indices = 32'(ic);
          r.out_bytes = 36'(byt);
        end
      end
      MODE_PUBLISH, MODE_ROLLBACK: begin
        if (!handle_ok(w, SLOT_RESERVED) || slot_pos[s] != pc || slot_idx[s] != ic ||
            slot_byt[s] != cb) st = STS_BAD_RESV;
        else begin
          r.out_slot = w.handle_slot;
          r.out_generation = w.handle_generation;
          r.out_positions = w.pos_count;
          r.out_indices = w.index_count;
          r.out_bytes = w.claimed_bytes;
          rsv_pos -= pc;
          rsv_idx -= ic;
          rsv_byt -= cb;
          if (w.mode == MODE_PUBLISH) begin
            slot_st[s] = SLOT_RESIDENT;
            res_pos += pc;
            res_idx += ic;
            res_byt += cb;
          end else begin
            free_slot(s);
          end
        end
      end
      MODE_GET, MODE_RELEASE: begin
        if (!handle_ok(w, SLOT_RESIDENT)) st = STS_BAD_HANDLE;
        else begin
          r.out_slot = w.handle_slot;
          r.out_generation = w.handle_generation;
          r.out_positions = 33'(slot_pos[s]);
          r.out_indices = 32'(slot_idx[s]);
          r.out_bytes = 36'(slot_byt[s]);
          if (w.mode == MODE_RELEASE) begin
            res_pos -= slot_pos[s];
            res_idx -= slot_idx[s];
            res_byt -= slot_byt[s];
            free_slot(s);
          end
        end
      end
      default: st = STS_BAD_HANDLE;
    endcase
    r.status = st;
  endtask

  // ---------------- drivers ----------------
  task automatic send_word(input in_word_t w, output out_word_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_bus.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_bus.valid <= 1'b1;
    in_bus.data <= w;
    do @(posedge clk); while (!in_bus.ready);
    pool_apply(w, r);
    pending_results.push_back(r);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send(input in_word_t w);
    out_word_t r;
    send_word(w, r);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data <= '{index: idx, data: 40'(val)};
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      CFG_POOL_ID:   pool_ident = 16'(val);
      CFG_POS_BUDG:  pos_limit = val & M40;
      CFG_IDX_BUDG:  idx_limit = val & M40;
      CFG_BYTE_BUDG: byte_limit = val & M40;
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic set_budgets(input logic [63:0] p, i, b);
    write_reg(CFG_POS_BUDG, p);
    write_reg(CFG_IDX_BUDG, i);
    write_reg(CFG_BYTE_BUDG, b);
  endtask

  // ---------------- word builders ----------------
  function automatic in_word_t noise_word();
    in_word_t w;
    w.mode = 3'($urandom);
    w.pos_count = 33'({$urandom, $urandom});
    w.index_count = $urandom;
    w.claimed_bytes = 36'({$urandom, $urandom});
    w.mesh_content_ok = 1'($urandom);
    w.handle_pool = 16'($urandom);
    w.handle_generation = 16'($urandom);
    w.handle_slot = 6'($urandom);
    return w;
  endfunction

  function automatic in_word_t reserve_word(input logic [32:0] pc, input logic [31:0] ic);
    in_word_t w;
    w = noise_word();
    w.mode = MODE_RESERVE;
    w.pos_count = pc;
    w.index_count = ic;
    w.mesh_content_ok = 1'b1;
    return w;
  endfunction

  // handle of slot s with its current claims
  function automatic in_word_t slot_word(input mode_t m, input int s);
    in_word_t w;
    w = noise_word();
    w.mode = m;
    w.handle_pool = pool_ident;
    w.handle_generation = slot_gen_m[s];
    w.handle_slot = 6'(s);
    w.pos_count = 33'(slot_pos[s]);
    w.index_count = 32'(slot_idx[s]);
    w.claimed_bytes = 36'(slot_byt[s]);
    return w;
  endfunction

  function automatic int pick_slot(input slot_state_t want);
    int hits[$];
    for (int i = 0; i < NSLOT; i++) if (slot_st[i] == want) hits.push_back(i);
    return (hits.size() == 0) ? -1 : hits[$urandom_range(0, hits.size() - 1)];
  endfunction

  function automatic in_word_t small_reserve();
    return reserve_word(33'($urandom_range(1, 4000)), 32'(3 * $urandom_range(1, 3000)));
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int r, s;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      w = small_reserve();
      case ($urandom_range(0, 19))
        0: w.pos_count = 33'($urandom_range(1, 32'hFFFF_FFFF)) + 33'($urandom_range(0, 1));
        1: w.index_count = 32'(3 * $urandom_range(1, 32'h5555_5555));
        2: w.mesh_content_ok = 1'b0;
        3: w.index_count = w.index_count + 32'($urandom_range(1, 2));
        4: w.pos_count = 33'h1_0000_0000 + 33'($urandom_range(0, 3));
        default: ;
      endcase
    end else if (r < 90) begin
      if (r < 65) s = pick_slot(SLOT_RESERVED);
      else s = pick_slot(SLOT_RESIDENT);
      if (s < 0) return small_reserve();
      if (r < 55) w = slot_word(MODE_PUBLISH, s);
      else if (r < 65) w = slot_word(MODE_ROLLBACK, s);
      else if (r < 78) w = slot_word(MODE_GET, s);
      else w = slot_word(MODE_RELEASE, s);
      case ($urandom_range(0, 19))
        0: w.pos_count = w.pos_count ^ 33'(1 << $urandom_range(0, 32));
        1: w.index_count = w.index_count + 32'd3;
        2: w.claimed_bytes = w.claimed_bytes ^ 36'(1 << $urandom_range(0, 35));
        3: w.handle_generation = w.handle_generation - 16'd1;
        4: w.handle_pool = w.handle_pool ^ 16'(1 << $urandom_range(0, 15));
        default: ;
      endcase
    end else begin
      w = noise_word();
    end
    return w;
  endfunction

  // ---------------- result checker ----------------
  task automatic check_field(input string nm, input logic [63:0] e, a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, nm, e, a);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t e, a;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
    if (rst_n && out_bus.valid && out_bus.ready) begin
      a = out_bus.data;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %0h", $time, a);
        fails++;
      end else begin
        e = pending_results.pop_front();
        check_field("status", 64'(e.status), 64'(a.status));
        check_field("slot", 64'(e.out_slot), 64'(a.out_slot));
        check_field("generation", 64'(e.out_generation), 64'(a.out_generation));
        check_field("positions", 64'(e.out_positions), 64'(a.out_positions));
        check_field("indices", 64'(e.out_indices), 64'(a.out_indices));
        check_field("bytes", 64'(e.out_bytes), 64'(a.out_bytes));
      end
    end
  end

  // receiver: ready pattern is drawn at random: always ready, random, or mostly low
  int rx_cnt = 0;
  int rx_pat = 0;
  always @(negedge clk) begin
    if (rx_cnt == 0) rx_pat = $urandom_range(0, 2);
    rx_cnt = (rx_cnt + 1) % 64;
    if (rx_pat == 0) out_bus.ready <= 1'b1;
    else if (rx_pat == 1) out_bus.ready <= 1'($urandom);
    else out_bus.ready <= ($urandom_range(0, 3) == 0);
  end

  // ---------------- tests ----------------
  task automatic test_mesh_rejects();
    in_word_t w;
    send(small_reserve());                        // pool still disabled
    w = small_reserve(); w.pos_count = 0; send(w);
    w = small_reserve(); w.index_count = 0; send(w);
    w = small_reserve(); w.index_count = 32'd4; send(w);
    w = small_reserve(); w.pos_count = 33'h1_0000_0001; send(w);
    w = small_reserve(); w.mesh_content_ok = 1'b0; send(w);
    w = noise_word(); w.mode = 3'd5; send(w);
    w = noise_word(); w.mode = 3'd7; send(w);
    wait_idle();
  endtask

  task automatic test_handle_lifecycle();
    in_word_t w;
    out_word_t r;
    int s;
    write_reg(CFG_POOL_ID, 64'hFFFF);
    send_word(reserve_word(33'h1_0000_0000, 32'hFFFF_FFFF), r);
    s = r.out_slot;
    w = slot_word(MODE_PUBLISH, s); w.claimed_bytes = w.claimed_bytes - 1; send(w);
    w = slot_word(MODE_GET, s); send(w);              // not resident yet
    send(slot_word(MODE_PUBLISH, s));
    send(slot_word(MODE_GET, s));
    w = slot_word(MODE_GET, s); w.handle_generation = 16'd1; send(w);
    w = slot_word(MODE_GET, s); w.handle_pool = 16'd1; send(w);
    send(slot_word(MODE_RELEASE, s));
    w.mode = MODE_GET; send(w);                       // stale handle
    send_word(small_reserve(), r);
    send(slot_word(MODE_ROLLBACK, r.out_slot));
    wait_idle();
  endtask

  task automatic test_budgets();
    out_word_t r;
    send_word(reserve_word(33'd100, 32'd30), r);
    send(slot_word(MODE_PUBLISH, r.out_slot));
    wait_idle();
    write_reg(CFG_POS_BUDG, 64'd50);                  // below what is charged
    send(reserve_word(33'd1, 32'd3));
    wait_idle();
    set_budgets(M40, 64'd10, M40);
    send(reserve_word(33'd1, 32'd3));
    wait_idle();
    set_budgets(M40, M40, 64'd1200 + 64'd120 + 64'd24);  // exact fit, then over
    send(reserve_word(33'd1, 32'd3));
    send(reserve_word(33'd2, 32'd6));
    wait_idle();
    set_budgets(M40, M40, M40);
  endtask

  task automatic test_pool_exhaust();
    int s;
    for (int i = 0; i <= NSLOT; i++) send(small_reserve());
    s = pick_slot(SLOT_RESERVED);
    while (s >= 0) begin
      send(slot_word(MODE_ROLLBACK, s));
      s = pick_slot(SLOT_RESERVED);
    end
    s = pick_slot(SLOT_RESIDENT);
    while (s >= 0) begin
      send(slot_word(MODE_RELEASE, s));
      s = pick_slot(SLOT_RESIDENT);
    end
    wait_idle();
  endtask

  task automatic test_random_phases();
    logic [63:0] lims[3];
    for (int ph = 0; ph < 6; ph++) begin
      for (int k = 0; k < 3; k++) begin
        case ((ph + k) % 4)
          0: lims[k] = M40;
          1: lims[k] = 64'd1;
          default: lims[k] = 64'($urandom_range(1000, 200000));
        endcase
      end
      write_reg(CFG_POOL_ID, (ph == 3) ? 64'd0 : 64'($urandom_range(1, 65535)));
      set_budgets(lims[0], lims[1], lims[2]);
      repeat (266) send(random_word());
      wait_idle();
    end
  endtask

  initial begin
    in_bus.valid = 1'b0;
    in_bus.data = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = '0;
    out_bus.ready = 1'b0;
    pool_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_mesh_rejects();
    test_handle_lifecycle();
    test_budgets();
    test_pool_exhaust();
    test_random_phases();
    wait_idle();
    if (fails == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
